// ===== design/rse_pkg.sv =====
package rse_pkg;

  // Lead length in bytes
  localparam int unsigned LEAD_BYTES = 96;

  // Lead magic and fixed field values
  localparam logic [7:0] LEAD_MAGIC0   = 8'hED;
  localparam logic [7:0] LEAD_MAGIC1   = 8'hAB;
  localparam logic [7:0] LEAD_MAGIC2   = 8'hEE;
  localparam logic [7:0] LEAD_MAGIC3   = 8'hDB;
  localparam logic [7:0] LEAD_SIG_TYPE = 8'h05;

  // Header and index entry sizes in bytes
  localparam int unsigned HDR_BYTES   = 16;
  localparam int unsigned ENTRY_BYTES = 16;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_NO_SIG   = 2'd2;

  // Register indexes
  localparam logic REG_SIG_TAG   = 1'b0;
  localparam logic REG_MIN_MAJOR = 1'b1;

  // Reset values of the registers
  localparam logic [30:0] SIG_TAG_RST   = 31'd1005;
  localparam logic [7:0]  MIN_MAJOR_RST = 8'd2;

  typedef struct packed {
    logic [30:0] sig_tag;
    logic [7:0]  min_major;
  } cfg_t;

  typedef struct packed {
    logic       sig_valid;
    logic [7:0] sig_byte;
    logic       sig_last;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== design/rpm_signature_extractor.sv =====
// A result beat is registered into the output register, or into the skid entry while the output is held.
// One byte per cycle is accepted while in_stall_o is low; the parse step is a single registered pass per byte.
// A two-entry output (register plus skid) lets input continue while a result waits.
// Reset (rst_ni low, asynchronous): parser returns to the lead phase, output empties,
// signature_tag goes to 1005 and min_major_version to 2.
module rpm_signature_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        sig_valid_o,
  output logic [7:0]  sig_byte_o,
  output logic        sig_last_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rse_pkg::*;

  logic        step;
  logic        res_valid;
  res_t        res, out_res;
  cfg_t        cfg;
  logic [30:0] sig_tag_q;
  logic [7:0]  min_major_q;
  logic        wr_en;

  // Register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_tag_q   <= SIG_TAG_RST;
      min_major_q <= MIN_MAJOR_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SIG_TAG:   sig_tag_q   <= pwdata[30:0];
        REG_MIN_MAJOR: min_major_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIG_TAG:   prdata = {1'b0, sig_tag_q};
      REG_MIN_MAJOR: prdata = {24'd0, min_major_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg.sig_tag   = sig_tag_q;
  assign cfg.min_major = min_major_q;

  // Input beat accepted
  assign step = in_valid_i && !in_stall_o;

  rse_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .cfg_i         (cfg),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  rse_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && res_valid),
    .res_i       (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign sig_valid_o = out_res.sig_valid;
  assign sig_byte_o  = out_res.sig_byte;
  assign sig_last_o  = out_res.sig_last;
  assign done_res_o  = out_res.done_res;
  assign status_o    = out_res.status;

endmodule

// ===== design/rse_parser.sv =====
module rse_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_file_i,
  input  rse_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output rse_pkg::res_t res_o
);
  import rse_pkg::*;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_ENTRY = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_SIG   = 3'd4;
  localparam logic [2:0] PH_PAD   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] byte_count_q, byte_count_d;
  logic        lead_good_q, lead_good_d;
  logic [31:0] entry_total_q, entry_total_d;
  logic [31:0] pad_end_q, pad_end_d;
  logic [95:0] word_shift_q, word_shift_d;
  logic [31:0] found_offset_q, found_offset_d;
  logic [31:0] found_count_q, found_count_d;

  logic [31:0] bc_inc;
  logic [95:0] ws_shift;
  logic        lead_bad;
  logic        idx_done;
  logic [31:0] idx_off, idx_cnt;
  logic        rep;
  logic [1:0]  rep_status;
  logic [31:0] hdr_entries, hdr_size;

  assign bc_inc   = byte_count_q + 32'd1;
  assign ws_shift = {word_shift_q[87:0], data_byte_i};
  assign hdr_entries = ws_shift[63:32];
  assign hdr_size    = ws_shift[31:0];

  // Lead byte checks
  always_comb begin
    lead_bad = 1'b0;
    case (byte_count_q)
      32'd0:  lead_bad = (data_byte_i != LEAD_MAGIC0);
      32'd1:  lead_bad = (data_byte_i != LEAD_MAGIC1);
      32'd2:  lead_bad = (data_byte_i != LEAD_MAGIC2);
      32'd3:  lead_bad = (data_byte_i != LEAD_MAGIC3);
      32'd4:  lead_bad = (data_byte_i < cfg_i.min_major);
      32'd6, 32'd7, 32'd78: lead_bad = (data_byte_i != 8'd0);
      32'd79: lead_bad = (data_byte_i != LEAD_SIG_TYPE);
      default: lead_bad = 1'b0;
    endcase
  end

  // Next state and result for one byte
  always_comb begin
    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    lead_good_d    = lead_good_q;
    entry_total_d  = entry_total_q;
    pad_end_d      = pad_end_q;
    word_shift_d   = word_shift_q;
    found_offset_d = found_offset_q;
    found_count_d  = found_count_q;
    res_valid_o    = 1'b0;
    res_o          = '0;
    idx_done       = 1'b0;
    idx_off        = found_offset_q;
    idx_cnt        = found_count_q;
    rep            = 1'b0;
    rep_status     = ST_OK;

    if (step_i && end_of_file_i) begin
      // file ended: report unless already reported, then start over
      if (phase_q != PH_DONE) begin
        res_valid_o = 1'b1;
        res_o.done_res = 1'b1;
        res_o.status = (phase_q == PH_LEAD) ? ST_BAD_LEAD : ST_NO_SIG;
      end
      phase_d        = PH_LEAD;
      byte_count_d   = '0;
      lead_good_d    = 1'b1;
      entry_total_d  = '0;
      pad_end_d      = '0;
      word_shift_d   = '0;
      found_offset_d = '1;
      found_count_d  = '0;
    end else if (step_i) begin
      case (phase_q)
        PH_LEAD: begin
          byte_count_d = bc_inc;
          if (lead_bad) lead_good_d = 1'b0;
          if (bc_inc >= 32'(LEAD_BYTES)) begin
            if (!lead_good_q || lead_bad) begin
              rep = 1'b1;
              rep_status = ST_BAD_LEAD;
            end else begin
              phase_d        = PH_HDR;
              byte_count_d   = '0;
              found_offset_d = '1;
              found_count_d  = '0;
            end
          end
        end
        PH_HDR: begin
          word_shift_d = ws_shift;
          byte_count_d = bc_inc;
          if (bc_inc >= 32'(HDR_BYTES)) begin
            entry_total_d = hdr_entries[31] ? 32'd0 : hdr_entries;
            // data size rounded up to a word; negative size means none
            pad_end_d = hdr_size[31] ? 32'd0 : ((hdr_size + 32'd3) & ~32'd3);
            byte_count_d = '0;
            if (hdr_entries[31] || hdr_entries == 32'd0) idx_done = 1'b1;
            else phase_d = PH_ENTRY;
          end
        end
        PH_ENTRY: begin
          // type field is dropped: keep tag, offset and count
          if (byte_count_q < 32'd4 || byte_count_q >= 32'd8) word_shift_d = ws_shift;
          byte_count_d = bc_inc;
          if (bc_inc >= 32'(ENTRY_BYTES)) begin
            if (ws_shift[95:64] == {1'b0, cfg_i.sig_tag}) begin
              found_offset_d = ws_shift[63:32];
              found_count_d  = ws_shift[31:0];
              idx_off        = ws_shift[63:32];
              idx_cnt        = ws_shift[31:0];
            end
            byte_count_d  = '0;
            entry_total_d = entry_total_q - 32'd1;
            if (entry_total_q == 32'd1) idx_done = 1'b1;
          end
        end
        PH_SKIP: begin
          byte_count_d = bc_inc;
          if (bc_inc >= found_offset_q) phase_d = PH_SIG;
        end
        PH_SIG: begin
          // found_count counts down the bytes still to send
          byte_count_d   = bc_inc;
          found_count_d  = found_count_q - 32'd1;
          res_valid_o    = 1'b1;
          res_o.sig_valid = 1'b1;
          res_o.sig_byte  = data_byte_i;
          if (found_count_q == 32'd1) begin
            res_o.sig_last = 1'b1;
            if (pad_end_q > bc_inc) begin
              phase_d = PH_PAD;
            end else begin
              res_o.done_res = 1'b1;
              res_o.status   = ST_OK;
              phase_d        = PH_DONE;
            end
          end
        end
        PH_PAD: begin
          byte_count_d = bc_inc;
          if (bc_inc >= pad_end_q) begin
            rep = 1'b1;
            rep_status = ST_OK;
          end
        end
        default: begin
        end
      endcase

      // end of index: check the kept entry
      if (idx_done) begin
        if (idx_off[31] || idx_cnt == 32'd0 || idx_cnt[31]) begin
          rep = 1'b1;
          rep_status = ST_NO_SIG;
        end else begin
          byte_count_d = '0;
          phase_d = (idx_off == 32'd0) ? PH_SIG : PH_SKIP;
        end
      end

      if (rep) begin
        res_valid_o    = 1'b1;
        res_o.done_res = 1'b1;
        res_o.status   = rep_status;
        phase_d        = PH_DONE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_LEAD;
      byte_count_q   <= '0;
      lead_good_q    <= 1'b1;
      entry_total_q  <= '0;
      pad_end_q      <= '0;
      word_shift_q   <= '0;
      found_offset_q <= '1;
      found_count_q  <= '0;
    end else begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      lead_good_q    <= lead_good_d;
      entry_total_q  <= entry_total_d;
      pad_end_q      <= pad_end_d;
      word_shift_q   <= word_shift_d;
      found_offset_q <= found_offset_d;
      found_count_q  <= found_count_d;
    end
  end

endmodule

// ===== design/rse_out_buf.sv =====
module rse_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rse_pkg::res_t res_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rse_pkg::res_t out_res_o
);
  import rse_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, skid_q;
  logic pop, load_out_new, load_out_skid, load_skid;

  assign pop    = out_valid_q && !out_stall_i;
  assign full_o = skid_valid_q;

  // Output register with one skid entry behind it
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out_new  = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (pop) out_valid_d = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        load_out_skid = 1'b1;
        out_valid_d   = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        load_out_new = 1'b1;
        out_valid_d  = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_out_new) out_q <= res_i;
    else if (load_out_skid) out_q <= skid_q;
    if (load_skid) skid_q <= res_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule
